// ===== src/smrq_pkg.sv =====
`default_nettype none

package smrq_pkg;

    localparam int unsigned SUM_W   = 32;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned DIVD_W  = 33;

    localparam logic [COUNT_W-1:0] MAX_WINDOW = 13'd4096;

    localparam logic signed [15:0] MEAN_MAX = 16'sd32767;
    localparam logic signed [15:0] MEAN_MIN = -16'sd32767;

    localparam logic [1:0] REG_MULTIPLIER = 2'd0;
    localparam logic [1:0] REG_SHIFT      = 2'd1;
    localparam logic [1:0] REG_COUNT      = 2'd2;

    localparam logic [30:0]        RESET_MULTIPLIER = 31'd1073741824;
    localparam logic signed [5:0]  RESET_SHIFT      = 6'sd1;
    localparam logic [COUNT_W-1:0] RESET_COUNT      = 13'd1;

    typedef struct packed {
        logic [30:0]        multiplier;
        logic signed [5:0]  shift;
        logic [COUNT_W-1:0] count;
    } cfg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ROUND,
        BK_RSHIFT,
        BK_DIV_START,
        BK_DIV_WAIT,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/spatial_mean_requantize_int16_unit.sv =====
// Spatial mean with int16 requantization.
// Samples enter on the sample channel (sample, window_end, sample_valid/sample_ready),
// one item per cycle; window_end marks the last sample of a window. Each window
// produces one item on the mean channel (mean_value, mean_valid/mean_ready).
// The front part sums samples at full rate and hands each finished sum to a
// two-entry queue. The back part requantizes one sum at a time: saturating left
// shift, multiply, rounding, rounding right shift, then a divide by the window
// count that retires one quotient bit per cycle, and a clamp to [-32767, 32767].
// A mean passes through the multiply, rounding, right-shift and divide states after
// the last sample of its window is taken; the divider dominates that time and the
// spacing of back-to-back means. Windows shorter than that fill the queue, and then sample_ready drops.
// A stalled receiver holds the mean in the output register; the back part keeps
// working on the next sum and waits only to hand over its result.
// Reset clears the running sum, the queue and all valid flags, and loads the
// registers with multiplier 2^30, shift 1 and window count 1. The registers sit
// at APB byte addresses 0, 4 and 8. The user must write them only while the block is idle; nothing enforces it.
`default_nettype none

module spatial_mean_requantize_int16_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    input  wire logic signed [15:0] sample,
    input  wire logic               window_end,
    output logic                    mean_valid,
    input  wire logic               mean_ready,
    output logic signed [15:0]      mean_value
);

    smrq_pkg::cfg_t cfg_reg;
    smrq_pkg::cfg_t cfg_next;
    logic           cfg_write;

    logic                       push;
    logic [smrq_pkg::SUM_W-1:0] push_sum;
    logic                       queue_full;
    logic                       queue_empty;
    logic                       pop;
    logic [smrq_pkg::SUM_W-1:0] pop_sum;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                smrq_pkg::REG_MULTIPLIER: cfg_next.multiplier = pwdata[30:0];
                smrq_pkg::REG_SHIFT:      cfg_next.shift      = signed'(pwdata[5:0]);
                smrq_pkg::REG_COUNT:      cfg_next.count      = pwdata[12:0];
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            smrq_pkg::REG_MULTIPLIER: prdata = {1'b0, cfg_reg.multiplier};
            smrq_pkg::REG_SHIFT:      prdata = {26'd0, cfg_reg.shift};
            smrq_pkg::REG_COUNT:      prdata = {19'd0, cfg_reg.count};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.multiplier <= smrq_pkg::RESET_MULTIPLIER;
            cfg_reg.shift      <= smrq_pkg::RESET_SHIFT;
            cfg_reg.count      <= smrq_pkg::RESET_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    smrq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .window_end   (window_end),
        .queue_full   (queue_full),
        .push         (push),
        .push_sum     (push_sum)
    );

    smrq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_sum),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .pop_data  (pop_sum)
    );

    smrq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .queue_data  (pop_sum),
        .pop         (pop),
        .mean_valid  (mean_valid),
        .mean_ready  (mean_ready),
        .mean_value  (mean_value)
    );

endmodule

`default_nettype wire

// ===== src/smrq_front.sv =====
`default_nettype none

module smrq_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      sample_valid,
    output logic                           sample_ready,
    input  wire logic signed [15:0]        sample,
    input  wire logic                      window_end,
    input  wire logic                      queue_full,
    output logic                           push,
    output logic [smrq_pkg::SUM_W-1:0]     push_sum
);

    logic [smrq_pkg::SUM_W-1:0] sum_reg;
    logic [smrq_pkg::SUM_W-1:0] sum_next;
    logic                       accept;

    assign sample_ready = !queue_full;
    assign accept       = sample_valid && sample_ready;
    assign push_sum     = sum_reg + {{(smrq_pkg::SUM_W-16){sample[15]}}, sample};
    assign push         = accept && window_end;

    always_comb
    begin
        sum_next = sum_reg;
        if (accept)
        begin
            sum_next = window_end ? '0 : push_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/smrq_fifo.sv =====
`default_nettype none

module smrq_fifo (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [smrq_pkg::SUM_W-1:0]    push_data,
    input  wire logic                          pop,
    output logic                               full,
    output logic                               empty,
    output logic [smrq_pkg::SUM_W-1:0]         pop_data
);

    logic [smrq_pkg::SUM_W-1:0] entry_reg [2];
    logic                       wr_ptr_reg;
    logic                       rd_ptr_reg;
    logic [1:0]                 count_reg;
    logic                       do_push;
    logic                       do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/smrq_div.sv =====
`default_nettype none

module smrq_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [smrq_pkg::DIVD_W-1:0]    dividend,
    input  wire logic [smrq_pkg::COUNT_W-1:0]   divisor,
    output logic                                done,
    output logic [smrq_pkg::DIVD_W-1:0]         quotient
);

    // Restoring division, one quotient bit per cycle, shifted into the dividend register.
    logic [smrq_pkg::DIVD_W-1:0]  quo_reg;
    logic [smrq_pkg::COUNT_W-1:0] rem_reg;
    logic [smrq_pkg::COUNT_W-1:0] div_reg;
    logic [5:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [smrq_pkg::COUNT_W:0]   trial;
    logic                         fits;

    assign trial    = {rem_reg, quo_reg[smrq_pkg::DIVD_W-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(smrq_pkg::DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[smrq_pkg::DIVD_W-2:0], fits};
            rem_reg <= fits ? smrq_pkg::COUNT_W'(trial - {1'b0, div_reg})
                            : smrq_pkg::COUNT_W'(trial);
        end
    end

endmodule

`default_nettype wire

// ===== src/smrq_back.sv =====
`default_nettype none

module smrq_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire smrq_pkg::cfg_t                cfg,
    input  wire logic                          queue_empty,
    input  wire logic [smrq_pkg::SUM_W-1:0]    queue_data,
    output logic                               pop,
    output logic                               mean_valid,
    input  wire logic                          mean_ready,
    output logic signed [15:0]                 mean_value
);

    smrq_pkg::back_state_t state_reg;
    smrq_pkg::back_state_t state_next;

    logic signed [31:0] acc_reg;
    logic signed [31:0] acc_next;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic signed [31:0] scaled_reg;
    logic signed [31:0] scaled_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] mean_reg;
    logic signed [15:0] mean_next;

    logic               div_start;
    logic               div_done;
    logic [smrq_pkg::DIVD_W-1:0]  div_dividend;
    logic [smrq_pkg::DIVD_W-1:0]  div_quotient;
    logic [smrq_pkg::COUNT_W-1:0] window_n;

    // Saturating left shift of the sum.
    logic signed [63:0] lshift_wide;
    logic signed [31:0] lshift_sat;
    logic               lshift_ovf;
    logic signed [31:0] head_sum;

    // Rounding doubling high multiply.
    logic signed [63:0] nudged;
    logic signed [63:0] high_part;
    logic signed [31:0] dhm;

    // Rounding right shift.
    logic [5:0]         rs_amt;
    logic signed [32:0] rs_x;
    logic signed [32:0] rs_floor;
    logic [32:0]        rs_mask;
    logic [32:0]        rs_rem;
    logic [32:0]        rs_thr;
    logic signed [31:0] rs_result;

    logic               mean_neg;
    logic [31:0]        mean_mag;
    logic [15:0]        quo_clamped;

    assign head_sum   = signed'(queue_data);
    assign lshift_wide = {{32{head_sum[31]}}, head_sum} <<< cfg.shift[4:0];
    assign lshift_ovf  = !((&lshift_wide[63:31]) || !(|lshift_wide[63:31]));
    assign lshift_sat  = lshift_ovf ? (head_sum[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                    : lshift_wide[31:0];

    assign nudged    = prod_reg + (prod_reg[63] ? (64'sd1 - (64'sd1 <<< 30))
                                                : (64'sd1 <<< 30));
    assign high_part = (nudged >>> 31)
                     + ((nudged[63] && (|nudged[30:0])) ? 64'sd1 : 64'sd0);
    assign dhm       = high_part[31:0];

    assign rs_amt    = 6'(-cfg.shift);
    assign rs_x      = {scaled_reg[31], scaled_reg};
    assign rs_floor  = rs_x >>> rs_amt;
    assign rs_mask   = (33'd1 << rs_amt) - 33'd1;
    assign rs_rem    = rs_x & rs_mask;
    assign rs_thr    = (rs_mask >> 1) + {32'd0, scaled_reg[31]};
    assign rs_result = rs_floor[31:0] + ((rs_rem > rs_thr) ? 32'sd1 : 32'sd0);

    // A zero count is used as one; counts above the window limit are clipped.
    assign window_n = (cfg.count == '0) ? smrq_pkg::COUNT_W'(1)
                    : (cfg.count > smrq_pkg::MAX_WINDOW) ? smrq_pkg::MAX_WINDOW
                    : cfg.count;

    // Round half away from zero: divide the magnitude plus half the count, then restore sign.
    assign mean_neg     = scaled_reg[31];
    assign mean_mag     = mean_neg ? 32'(-scaled_reg) : 32'(scaled_reg);
    assign div_dividend = {1'b0, mean_mag}
                        + {{(smrq_pkg::DIVD_W-smrq_pkg::COUNT_W){1'b0}}, window_n >> 1};
    assign quo_clamped  = (div_quotient > smrq_pkg::DIVD_W'(smrq_pkg::MEAN_MAX))
                        ? 16'(smrq_pkg::MEAN_MAX) : div_quotient[15:0];

    assign mean_valid = out_valid_reg;
    assign mean_value = mean_reg;

    smrq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (window_n),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        scaled_next    = scaled_reg;
        out_valid_next = out_valid_reg;
        mean_next      = mean_reg;
        pop            = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && mean_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            smrq_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    acc_next   = (cfg.shift > 6'sd0) ? lshift_sat : head_sum;
                    state_next = smrq_pkg::BK_MUL;
                end
            end
            smrq_pkg::BK_MUL:
            begin
                prod_next  = acc_reg * signed'({1'b0, cfg.multiplier});
                state_next = smrq_pkg::BK_ROUND;
            end
            smrq_pkg::BK_ROUND:
            begin
                scaled_next = dhm;
                state_next  = smrq_pkg::BK_RSHIFT;
            end
            smrq_pkg::BK_RSHIFT:
            begin
                if (cfg.shift < 6'sd0)
                begin
                    scaled_next = rs_result;
                end
                state_next = smrq_pkg::BK_DIV_START;
            end
            smrq_pkg::BK_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = smrq_pkg::BK_DIV_WAIT;
            end
            smrq_pkg::BK_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = smrq_pkg::BK_EMIT;
                end
            end
            smrq_pkg::BK_EMIT:
            begin
                if (!out_valid_reg || mean_ready)
                begin
                    out_valid_next = 1'b1;
                    mean_next      = mean_neg ? 16'(-signed'(quo_clamped))
                                              : signed'(quo_clamped);
                    state_next     = smrq_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = smrq_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smrq_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        mean_reg   <= mean_next;
    end

endmodule

`default_nettype wire

// ===== dv/spatial_mean_requantize_int16_unit_tb.sv =====
`default_nettype none

module spatial_mean_requantize_int16_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -S32_MAX - 1;
    localparam int unsigned Q31_ONE_HALF = 32'd1073741824;
    localparam int unsigned Q31_MAX = 32'd2147483647;
    localparam int SETTLE_CYCLES = 60;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               sample_valid;
    logic               sample_ready;
    logic signed [15:0] sample;
    logic               window_end;
    logic               mean_valid;
    logic               mean_ready;
    logic signed [15:0] mean_value;

    // Mirror of the block's registers and window accumulator.
    smrq_pkg::cfg_t     scaling;
    logic [31:0]        window_sum;
    logic signed [15:0] pending_means[$];

    int  fail_count;
    int  samples_sent;
    bit  gaps_on;
    int  ready_hold;

    spatial_mean_requantize_int16_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .window_end   (window_end),
        .mean_valid   (mean_valid),
        .mean_ready   (mean_ready),
        .mean_value   (mean_value)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #24_000_000;
        $display("status: fail");
        $finish;
    end

    // Requantize a finished window sum and divide it by the window count.
    function automatic logic signed [15:0] window_mean(logic [31:0] sum, smrq_pkg::cfg_t c);
        longint acc;
        longint prod;
        longint nudge;
        longint scaled;
        longint n;
        longint q;
        longint unsigned mask;
        longint unsigned rem;
        longint unsigned threshold;
        int sh;
        acc = longint'(signed'(sum));
        sh = $signed(c.shift);
        if (sh > 0)
        begin
            acc = acc * (longint'(1) << sh);
            if (acc > S32_MAX)
                acc = S32_MAX;
            else if (acc < S32_MIN)
                acc = S32_MIN;
        end
        prod = acc * longint'({33'b0, c.multiplier});
        nudge = (prod >= 0) ? (longint'(1) << 30) : (longint'(1) - (longint'(1) << 30));
        scaled = (prod + nudge) / (longint'(1) << 31);
        if (sh < 0)
        begin
            mask = (64'd1 << (-sh)) - 64'd1;
            rem = longint'(scaled) & mask;
            threshold = (mask >> 1) + ((scaled < 0) ? 64'd1 : 64'd0);
            scaled = scaled >>> (-sh);
            if (rem > threshold)
                scaled = scaled + 1;
        end
        n = longint'({51'b0, c.count});
        if (n == 0)
            n = 1;
        if (n > longint'({51'b0, smrq_pkg::MAX_WINDOW}))
            n = longint'({51'b0, smrq_pkg::MAX_WINDOW});
        if (scaled > 0)
            q = (scaled + n / 2) / n;
        else
            q = (scaled - n / 2) / n;
        if (q < longint'(smrq_pkg::MEAN_MIN))
            q = longint'(smrq_pkg::MEAN_MIN);
        if (q > longint'(smrq_pkg::MEAN_MAX))
            q = longint'(smrq_pkg::MEAN_MAX);
        return q[15:0];
    endfunction

    always @(posedge clk)
    begin : check_means
        logic signed [15:0] want;
        if (rst_n && mean_valid && mean_ready)
        begin
            if (pending_means.size() == 0)
            begin
                $error("mean_value: no mean expected, actual %0d", mean_value);
                fail_count++;
            end
            else
            begin
                want = pending_means.pop_front();
                if (mean_value !== want)
                begin
                    $error("mean_value: expected %0d, actual %0d", want, mean_value);
                    fail_count++;
                end
            end
        end
    end

    // The receiver stalls in bursts while gaps are enabled.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (gaps_on && $urandom_range(0, 11) == 0)
        begin
            mean_ready <= 1'b0;
            ready_hold <= $urandom_range(0, 17);
        end
        else
            mean_ready <= 1'b1;
    end

    task automatic send_sample(logic signed [15:0] value, logic last);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= value;
        window_end <= last;
        do
            @(posedge clk);
        while (!sample_ready);
        samples_sent++;
        window_sum = window_sum + 32'(signed'(value));
        if (last)
        begin
            pending_means.push_back(window_mean(window_sum, scaling));
            window_sum = '0;
        end
    endtask

    // Stop the sample stream and let every outstanding mean come back.
    task automatic wait_for_means();
        sample_valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
        logic [31:0] mask;
        case (reg_idx)
            smrq_pkg::REG_MULTIPLIER:
            begin
                scaling.multiplier = value[30:0];
                mask = 32'h7FFF_FFFF;
            end
            smrq_pkg::REG_SHIFT:
            begin
                scaling.shift = value[5:0];
                mask = 32'h0000_003F;
            end
            default:
            begin
                scaling.count = value[smrq_pkg::COUNT_W-1:0];
                mask = 32'h0000_1FFF;
            end
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Read the register back through the same port.
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== (value & mask))
        begin
            $error("prdata: expected %0h, actual %0h", value & mask, prdata & mask);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_scaling(int unsigned multiplier, int shift, int unsigned count);
        wait_for_means();
        apb_write(smrq_pkg::REG_MULTIPLIER, multiplier);
        apb_write(smrq_pkg::REG_SHIFT, 32'(shift));
        apb_write(smrq_pkg::REG_COUNT, count);
    endtask

    function automatic logic signed [15:0] pick_sample(int style);
        case (style)
            0: return ($urandom_range(0, 1) != 0) ? smrq_pkg::MEAN_MAX : 16'sh8000;
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_window(int len, int style);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(style), i == len - 1);
    endtask

    task automatic test_reset_defaults();
        // Reset scaling is the identity, so each single-sample window returns itself, clamped to [-32767, 32767].
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b1);
    endtask

    task automatic test_multiplier_extremes();
        set_scaling(0, 1, 1);
        send_sample(16'sd12345, 1'b1);
        set_scaling(Q31_MAX, 0, 1);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b1);
        set_scaling(1, 31, 1);
        send_sample(16'sd32767, 1'b1);
    endtask

    task automatic test_shift_extremes();
        // Large left shifts saturate the sum before the multiply; the later cases use right shifts.
        set_scaling(Q31_MAX, 31, 2);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd1, 1'b1);
        set_scaling(Q31_ONE_HALF, 30, 1);
        send_sample(-16'sd3, 1'b1);
        set_scaling(Q31_MAX, -32, 1);
        send_sample(16'sd32767, 1'b1);
        set_scaling(Q31_MAX, -31, 1);
        send_sample(-16'sd32768, 1'b1);
        set_scaling(Q31_ONE_HALF, -1, 1);
        send_sample(16'sd3, 1'b1);
    endtask

    task automatic test_count_extremes();
        set_scaling(Q31_ONE_HALF, 12, 0);
        send_sample(16'sd5, 1'b1);
        set_scaling(Q31_ONE_HALF, 16, 4096);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b1);
        set_scaling(Q31_ONE_HALF, 16, 4097);
        send_sample(-16'sd32768, 1'b1);
        set_scaling(Q31_ONE_HALF, 16, 8191);
        send_sample(16'sd12288, 1'b1);
        // Halves round away from zero on both signs.
        set_scaling(Q31_ONE_HALF, 1, 2);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd2, 1'b1);
    endtask

    task automatic test_long_windows();
        // Windows longer than the count push the mean past the output range.
        set_scaling(Q31_ONE_HALF, 1, 64);
        gaps_on = 1'b0;
        for (int i = 0; i < 100; i++)
            send_sample(16'sd32767, i == 99);
        for (int i = 0; i < 100; i++)
            send_sample(-16'sd32768, i == 99);
    endtask

    task automatic test_random_windows(int item_budget);
        int start;
        int eff;
        int nwin;
        int len;
        int unsigned multiplier;
        int shift;
        int unsigned count;
        start = samples_sent;
        while (samples_sent - start < item_budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: multiplier = Q31_ONE_HALF;
                5, 6, 7: multiplier = $urandom_range(0, Q31_MAX);
                8: multiplier = Q31_MAX;
                default: multiplier = $urandom_range(0, 1);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: shift = 1;
                5, 6, 7: shift = $signed($urandom_range(0, 12)) - 8;
                8: shift = ($urandom_range(0, 1) != 0) ? 31 : 30;
                default: shift = $signed($urandom_range(0, 63)) - 32;
            endcase
            case ($urandom_range(0, 19))
                0: count = 0;
                1: count = 4096;
                2: count = $urandom_range(4097, 8191);
                3: count = $urandom_range(65, 8191);
                4, 5, 6: count = $urandom_range(17, 64);
                default: count = $urandom_range(1, 16);
            endcase
            set_scaling(multiplier, shift, count);
            gaps_on = $urandom_range(0, 3) != 0;
            eff = (count == 0) ? 1 : ((count > 4096) ? 4096 : count);
            nwin = $urandom_range(3, 12);
            for (int w = 0; w < nwin; w++)
            begin
                if (eff > 64)
                    len = $urandom_range(1, 8);
                else if ($urandom_range(0, 4) != 0)
                    len = eff;
                else
                    len = $urandom_range(1, 2 * eff);
                send_window(len, $urandom_range(0, 4));
                if ($urandom_range(0, 24) == 0)
                    wait_for_means();
            end
        end
    endtask

    task automatic test_streaming_tail(int item_budget);
        int start;
        set_scaling(Q31_ONE_HALF, 1, $urandom_range(1, 8));
        gaps_on = 1'b0;
        start = samples_sent;
        while (samples_sent - start < item_budget)
            send_window(scaling.count, 2);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_valid = 1'b0;
        sample = '0;
        window_end = 1'b0;
        mean_ready = 1'b0;
        ready_hold = 0;
        fail_count = 0;
        samples_sent = 0;
        gaps_on = 1'b1;
        window_sum = '0;
        scaling.multiplier = smrq_pkg::RESET_MULTIPLIER;
        scaling.shift = smrq_pkg::RESET_SHIFT;
        scaling.count = smrq_pkg::RESET_COUNT;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_multiplier_extremes();
        test_shift_extremes();
        test_count_extremes();
        gaps_on = 1'b1;
        test_random_windows(1250);
        test_long_windows();
        test_streaming_tail(200);
        wait_for_means();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/smrq_pkg.sv
src/smrq_front.sv
src/smrq_fifo.sv
src/smrq_div.sv
src/smrq_back.sv
src/spatial_mean_requantize_int16_unit.sv
dv/spatial_mean_requantize_int16_unit_tb.sv
